// ----- hdl/mcmp_pkg.sv -----
// shared types and constants for the midi channel message parser
`default_nettype none

package mcmp_pkg;

  // upper nibble of a status byte
  typedef enum logic [3:0] {
    KIND_NOTE_OFF  = 4'h8,
    KIND_NOTE_ON   = 4'h9,
    KIND_POLY_PRES = 4'hA,
    KIND_CTRL      = 4'hB,
    KIND_PROGRAM   = 4'hC,
    KIND_CHAN_PRES = 4'hD,
    KIND_BEND      = 4'hE,
    KIND_SYSTEM    = 4'hF
  } kind_t;

  // decoded command codes
  typedef enum logic [2:0] {
    CMD_KEY_OFF = 3'd0,
    CMD_KEY_ON  = 3'd1,
    CMD_CTRL    = 3'd2,
    CMD_PROGRAM = 3'd3,
    CMD_BEND    = 3'd4
  } cmd_t;

  localparam logic [6:0]  KeyOffVelocity = 7'h40;
  localparam logic [13:0] BendCenter     = 14'd8192;
  localparam logic [4:0]  NumPartsReset  = 5'd16;

  // one assembled channel message
  typedef struct packed {
    logic [7:0] status;
    logic [6:0] d1;
    logic [6:0] d2;
  } msg_t;

endpackage

`default_nettype wire

// ----- hdl/mcmp_byte_if.sv -----
// byte stream channel
`default_nettype none

interface mcmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ----- hdl/mcmp_msg_if.sv -----
// decoded message result channel
`default_nettype none

interface mcmp_msg_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [3:0]         part;
  logic [6:0]         note_or_number;
  logic [6:0]         velocity_or_value;
  logic signed [13:0] bend_value;

  modport source (output valid, output command, output part, output note_or_number,
                  output velocity_or_value, output bend_value, input ready);
  modport sink (input valid, input command, input part, input note_or_number,
                input velocity_or_value, input bend_value, output ready);
endinterface

`default_nettype wire

// ----- hdl/mcmp_cfg_if.sv -----
// configuration write channel for the part count
`default_nettype none

interface mcmp_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] num_parts;

  modport source (output valid, output num_parts, input ready);
  modport sink (input valid, input num_parts, output ready);
endinterface

`default_nettype wire

// ----- hdl/mcmp_framer.sv -----
// byte framer: collects status and data bytes into complete channel messages
`default_nettype none

module mcmp_framer (
  input  wire logic     clk,
  input  wire logic     rst_n,
  mcmp_byte_if.sink     in_ch,
  output mcmp_pkg::msg_t msg,
  output logic          msg_valid,
  input  wire logic     msg_ready
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_WAIT1 = 2'd1,
    ST_WAIT2 = 2'd2
  } state_t;

  state_t         state_r, state_nxt;
  logic [7:0]     held_status_r, held_status_nxt;
  logic [6:0]     held_first_r, held_first_nxt;
  mcmp_pkg::msg_t msg_r, msg_nxt;
  logic           msg_valid_r, msg_valid_nxt;
  logic           in_acc;
  logic           is_status;
  logic           is_system;
  logic           emit;
  logic [3:0]     held_kind;

  assign in_ch.ready = !msg_valid_r || msg_ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_status   = in_ch.in_byte[7];
  assign is_system   = in_ch.in_byte[7:4] == mcmp_pkg::KIND_SYSTEM;
  assign held_kind   = held_status_r[7:4];

  // next state and message assembly
  always_comb begin
    state_nxt       = state_r;
    held_status_nxt = held_status_r;
    held_first_nxt  = held_first_r;
    msg_nxt         = msg_r;
    emit            = 1'b0;
    if (in_acc && !is_system) begin
      case (state_r)
        ST_WAIT1: begin
          if (!is_status) begin
            held_first_nxt = in_ch.in_byte[6:0];
            if (held_kind == mcmp_pkg::KIND_PROGRAM ||
                held_kind == mcmp_pkg::KIND_CHAN_PRES) begin
              emit      = 1'b1;
              msg_nxt   = '{status: held_status_r, d1: in_ch.in_byte[6:0], d2: 7'd0};
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_WAIT2;
            end
          end
        end
        ST_WAIT2: begin
          if (!is_status) begin
            emit      = 1'b1;
            msg_nxt   = '{status: held_status_r, d1: held_first_r, d2: in_ch.in_byte[6:0]};
            state_nxt = ST_IDLE;
          end
        end
        default: begin
          if (is_status) begin
            held_status_nxt = in_ch.in_byte;
            state_nxt       = ST_WAIT1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      endcase
    end
    if (emit) begin
      msg_valid_nxt = 1'b1;
    end else if (msg_ready) begin
      msg_valid_nxt = 1'b0;
    end else begin
      msg_valid_nxt = msg_valid_r;
    end
  end

  // state and message register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      held_status_r <= 8'd0;
      held_first_r  <= 7'd0;
      msg_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      held_status_r <= held_status_nxt;
      held_first_r  <= held_first_nxt;
      msg_valid_r   <= msg_valid_nxt;
    end
    msg_r <= msg_nxt;
  end

  assign msg       = msg_r;
  assign msg_valid = msg_valid_r;

`ifndef NO_ASSERTIONS
  // a waiting state always holds a real status byte
  a_held_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> held_status_r[7])
    else $error("framer waits with a non-status byte held");

  // a second data byte completes the message
  a_wait2_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && state_r == ST_WAIT2 && !is_status)
      |=> (state_r == ST_IDLE && msg_valid_r))
    else $error("second data byte did not complete a message");

  // an emitted message carries a channel status
  a_msg_status: assert property (@(posedge clk) disable iff (!rst_n)
    msg_valid_r |-> (msg_r.status[7] && msg_r.status[7:4] != mcmp_pkg::KIND_SYSTEM))
    else $error("message without channel status");
`endif

endmodule

`default_nettype wire

// ----- hdl/mcmp_decoder.sv -----
// message decoder with part filter, part-count register and result register
`default_nettype none

module mcmp_decoder (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire mcmp_pkg::msg_t  msg,
  input  wire logic            msg_valid,
  output logic                 msg_ready,
  mcmp_cfg_if.sink             cfg_ch,
  mcmp_msg_if.source           out_ch
);

  logic [4:0]         num_parts_r;
  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         command_r, command_nxt;
  logic [3:0]         part_r;
  logic [6:0]         note_r, note_nxt;
  logic [6:0]         vel_r, vel_nxt;
  logic signed [13:0] bend_r, bend_nxt;
  logic               take;
  logic               hit;
  logic               part_ok;
  logic [3:0]         kind;

  assign cfg_ch.ready = 1'b1;
  assign msg_ready    = !out_valid_r || out_ch.ready;
  assign take         = msg_valid && msg_ready;
  assign kind         = msg.status[7:4];
  assign part_ok      = {1'b0, msg.status[3:0]} < num_parts_r;

  // decode one message into result fields
  always_comb begin
    hit         = 1'b0;
    command_nxt = mcmp_pkg::CMD_KEY_OFF;
    note_nxt    = msg.d1;
    vel_nxt     = msg.d2;
    bend_nxt    = 14'sd0;
    case (kind)
      mcmp_pkg::KIND_NOTE_OFF: begin
        hit = 1'b1;
      end
      mcmp_pkg::KIND_NOTE_ON: begin
        hit = 1'b1;
        if (msg.d2 == 7'd0) begin
          vel_nxt = mcmp_pkg::KeyOffVelocity;
        end else begin
          command_nxt = mcmp_pkg::CMD_KEY_ON;
        end
      end
      mcmp_pkg::KIND_CTRL: begin
        hit         = 1'b1;
        command_nxt = mcmp_pkg::CMD_CTRL;
      end
      mcmp_pkg::KIND_PROGRAM: begin
        hit         = 1'b1;
        command_nxt = mcmp_pkg::CMD_PROGRAM;
        vel_nxt     = 7'd0;
      end
      mcmp_pkg::KIND_BEND: begin
        hit         = 1'b1;
        command_nxt = mcmp_pkg::CMD_BEND;
        note_nxt    = 7'd0;
        vel_nxt     = 7'd0;
        bend_nxt    = $signed({msg.d2, msg.d1} - mcmp_pkg::BendCenter);
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    hit = hit && part_ok;
    if (take) begin
      out_valid_nxt = hit;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // part count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_parts_r <= mcmp_pkg::NumPartsReset;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        num_parts_r <= cfg_ch.num_parts;
      end
      out_valid_r <= out_valid_nxt;
    end
    if (take) begin
      command_r <= command_nxt;
      part_r    <= msg.status[3:0];
      note_r    <= note_nxt;
      vel_r     <= vel_nxt;
      bend_r    <= bend_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.command           = command_r;
  assign out_ch.part              = part_r;
  assign out_ch.note_or_number    = note_r;
  assign out_ch.velocity_or_value = vel_r;
  assign out_ch.bend_value        = bend_r;

`ifndef NO_ASSERTIONS
  // only pitch bend carries a bend value
  a_bend_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && command_r != mcmp_pkg::CMD_BEND) |-> bend_r == 14'sd0)
    else $error("bend value set on a non-bend result");

  // key on never has zero velocity
  a_key_on_vel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && command_r == mcmp_pkg::CMD_KEY_ON) |-> vel_r != 7'd0)
    else $error("key on with zero velocity");
`endif

endmodule

`default_nettype wire

// ----- hdl/midi_channel_message_parser.sv -----
// Top level of the MIDI channel message parser.
// in_ch carries one raw MIDI byte per request (valid/ready, accepted when
// both are high). System bytes 0xF0-0xFF are dropped; a status byte opens
// a message when idle, program change and channel pressure close after one
// data byte, the other kinds after two. Stray bytes are dropped.
// out_ch carries one decoded result per completed message whose part is
// below num_parts: key off, key on, control change, program change or
// pitch bend. Pressure messages give no result.
// cfg_ch writes num_parts (reset 16); it is always ready.
// Throughput: one byte per cycle while in_ch.ready is high. The framer
// registers a completed message in the message register on the edge that
// accepts its last byte; the decoder then moves it into the result
// register once that register is empty or out_ch.ready is high.
// Stalls: the message register and the result register form two stages;
// in_ch.ready drops only when both hold data and out_ch.ready is low.
// Reset (rst_n low, synchronous) returns the framer to idle, empties both
// stages and sets num_parts to 16.
`default_nettype none

module midi_channel_message_parser (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mcmp_byte_if.sink  in_ch,
  mcmp_cfg_if.sink   cfg_ch,
  mcmp_msg_if.source out_ch
);

  mcmp_pkg::msg_t msg;
  logic           msg_valid;
  logic           msg_ready;

  // byte framing
  mcmp_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .msg       (msg),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready)
  );

  // decoding and result register
  mcmp_decoder u_decoder (
    .clk       (clk),
    .rst_n     (rst_n),
    .msg       (msg),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .cfg_ch    (cfg_ch),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
